// ----- sv/lrsf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrsf_pkg: shared types and constants of the LPC residual synthesis filter
// Widths of the item fields, op codes, FSM states, the MAC control bundle
// and the mu-law excitation decoder.
// ----------------------------------------------------------------------------
package lrsf_pkg;

  // default filter order (taps = order - 1)
  localparam int FILTER_ORDER_DEF = 47;

  // field widths
  localparam int OP_W       = 2;
  localparam int TAP_IDX_W  = 6;
  localparam int TAP_W      = 20;
  localparam int BYTE_W     = 8;
  localparam int SAMPLE_W   = 16;
  localparam int HIST_W     = 24;
  localparam int EXC_W      = 17;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = TAP_W + HIST_W;
  // covers 63 full-scale products plus the shifted excitation
  localparam int ACC_W      = 52;
  localparam int QUOT_W     = ACC_W - FRAC_W;

  // output limits
  localparam logic signed [HIST_W-1:0]   OUT_LIMIT = HIST_W'(32766);
  localparam logic signed [QUOT_W-1:0]   HIST_MAX  = QUOT_W'(8388607);
  localparam logic signed [QUOT_W-1:0]   HIST_MIN  = -QUOT_W'(8388608);

  // op codes
  localparam logic [OP_W-1:0] OP_LOAD     = 2'd0;
  localparam logic [OP_W-1:0] OP_RESIDUAL = 2'd1;
  localparam logic [OP_W-1:0] OP_START    = 2'd2;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_DONE
  } lrsf_state_e;

  // control bundle from sequencer to MAC
  typedef struct packed {
    logic                    start;    // load accumulator with excitation
    logic signed [EXC_W-1:0] exc;      // decoded excitation sample
    logic                    mul_en;   // RAM read data valid this cycle
    logic                    hist_ok;  // history entry holds written data
    logic                    finish;   // scale and saturate accumulator
  } lrsf_mac_ctl_t;

  // mu-law segment bases (bias of 132 removed)
  localparam logic [15:0] MULAW_BASE [8] = '{
    16'd0, 16'd132, 16'd396, 16'd924, 16'd1980, 16'd4092, 16'd8316, 16'd16764
  };

  function automatic logic signed [EXC_W-1:0] mulaw_decode(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] u;
    logic [2:0]        e;
    logic [15:0]       mag;
    u   = ~b;
    e   = u[6:4];
    mag = MULAW_BASE[e] + (16'(u[3:0]) << (4'(e) + 4'd3));
    if (u[7]) begin
      mulaw_decode = -$signed({1'b0, mag});
    end else begin
      mulaw_decode = $signed({1'b0, mag});
    end
  endfunction

endpackage

// ----- sv/lrsf_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrsf_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lrsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/lrsf_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrsf_mac: shared multiply-accumulate unit
// Registered tap x history product, exact accumulator, then truncation
// toward zero of the Q16 result and saturation to the history width.
// ----------------------------------------------------------------------------
module lrsf_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lrsf_pkg::lrsf_mac_ctl_t              ctl_i,
  input  logic signed [lrsf_pkg::TAP_W-1:0]    tap_i,
  input  logic signed [lrsf_pkg::HIST_W-1:0]   hist_i,
  output logic                                 busy_o,
  output logic signed [lrsf_pkg::HIST_W-1:0]   y_o
);
  import lrsf_pkg::*;

  logic                     pv_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [HIST_W-1:0] y_q;
  logic signed [HIST_W-1:0] hist_m;
  logic signed [QUOT_W-1:0] quot;
  logic signed [QUOT_W-1:0] quot_tz;
  logic signed [HIST_W-1:0] y_d;

  // unwritten history entries read as zero
  assign hist_m = ctl_i.hist_ok ? hist_i : '0;

  // product valid token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= ctl_i.mul_en;
    end
  end

  // multiply stage and accumulator
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= tap_i * hist_m;
    end
    if (ctl_i.start) begin
      acc_q <= ACC_W'(ctl_i.exc) <<< FRAC_W;
    end else if (pv_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (ctl_i.finish) begin
      y_q <= y_d;
    end
  end

  // divide by 2^16 toward zero, saturate to history range
  always_comb begin
    quot    = acc_q[ACC_W-1:FRAC_W];
    quot_tz = quot + QUOT_W'(acc_q[ACC_W-1] && (acc_q[FRAC_W-1:0] != '0));
    if (quot_tz > HIST_MAX) begin
      y_d = HIST_MAX[HIST_W-1:0];
    end else if (quot_tz < HIST_MIN) begin
      y_d = HIST_MIN[HIST_W-1:0];
    end else begin
      y_d = quot_tz[HIST_W-1:0];
    end
  end

  assign busy_o = pv_q;
  assign y_o    = y_q;

endmodule

// ----- sv/lpc_residual_synthesis_filter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_residual_synthesis_filter_top: residual-excited LPC synthesis filter
// All-pole filter with mu-law excitation; taps and history kept in RAMs.
// ----------------------------------------------------------------------------
// The block takes no new item while a residual item is in work: one MAC
// shared by all FILTER_ORDER - 1 taps reads one tap and one history entry per
// cycle from the two RAMs, followed by pipeline drain and scaling and then the
// history write-back. Load and start items produce no result and leave the
// block ready for the next item. The result sits in an output register, so a
// new item is accepted while the previous sample waits to be taken.
// Out-of-range tap loads and the unused op code are dropped.
// ----------------------------------------------------------------------------
module lpc_residual_synthesis_filter_top #(
  parameter int FILTER_ORDER = lrsf_pkg::FILTER_ORDER_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [lrsf_pkg::OP_W-1:0]              op_i,
  input  logic [lrsf_pkg::TAP_IDX_W-1:0]         tap_index_i,
  input  logic signed [lrsf_pkg::TAP_W-1:0]      tap_value_i,
  input  logic [lrsf_pkg::BYTE_W-1:0]            residual_byte_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [lrsf_pkg::SAMPLE_W-1:0]   speech_sample_o
);
  import lrsf_pkg::*;

  localparam int NUM_TAPS = FILTER_ORDER - 1;
  localparam int AW       = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
  localparam logic [AW-1:0] LAST = AW'(NUM_TAPS - 1);

  lrsf_state_e         state_q, state_d;
  logic [AW-1:0]       k_q, k_d;
  logic [AW-1:0]       slot_q, slot_d;
  logic [AW-1:0]       ptr_q, ptr_d;
  logic                tok_q, tok_d;
  logic                hv_q, hv_d;
  logic [NUM_TAPS-1:0] hvld_q, hvld_d;
  logic                out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] out_q, out_d;

  logic                accept;
  logic                tap_we;
  logic                rd_en;
  logic                hist_we;
  logic signed [TAP_W-1:0]  tap_rd;
  logic signed [HIST_W-1:0] hist_rd;
  logic signed [HIST_W-1:0] y;
  logic                mac_busy;
  lrsf_mac_ctl_t       mac_ctl;
  logic signed [SAMPLE_W-1:0] clamped;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign tap_we     = accept && (op_i == OP_LOAD) &&
                      (7'(tap_index_i) < 7'(NUM_TAPS));

  // coefficient store
  lrsf_ram #(
    .WIDTH (TAP_W),
    .DEPTH (NUM_TAPS)
  ) u_tap_ram (
    .clk_i   (clk_i),
    .we_i    (tap_we),
    .waddr_i (tap_index_i[AW-1:0]),
    .wdata_i (tap_value_i),
    .re_i    (rd_en),
    .raddr_i (k_q),
    .rdata_o (tap_rd)
  );

  // output history ring
  lrsf_ram #(
    .WIDTH (HIST_W),
    .DEPTH (NUM_TAPS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (ptr_q),
    .wdata_i (y),
    .re_i    (rd_en),
    .raddr_i (slot_q),
    .rdata_o (hist_rd)
  );

  lrsf_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .tap_i  (tap_rd),
    .hist_i (hist_rd),
    .busy_o (mac_busy),
    .y_o    (y)
  );

  // output clamp
  always_comb begin
    if (y > OUT_LIMIT) begin
      clamped = OUT_LIMIT[SAMPLE_W-1:0];
    end else if (y < -OUT_LIMIT) begin
      clamped = SAMPLE_W'(-OUT_LIMIT);
    end else begin
      clamped = y[SAMPLE_W-1:0];
    end
  end

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      slot_q      <= '0;
      ptr_q       <= '0;
      tok_q       <= 1'b0;
      hv_q        <= 1'b0;
      hvld_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      slot_q      <= slot_d;
      ptr_q       <= ptr_d;
      tok_q       <= tok_d;
      hv_q        <= hv_d;
      hvld_q      <= hvld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output sample register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    slot_d      = slot_q;
    ptr_d       = ptr_q;
    tok_d       = 1'b0;
    hv_d        = 1'b0;
    hvld_d      = hvld_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    rd_en       = 1'b0;
    hist_we     = 1'b0;
    mac_ctl     = '0;
    mac_ctl.exc     = mulaw_decode(residual_byte_i);
    mac_ctl.mul_en  = tok_q;
    mac_ctl.hist_ok = hv_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_i)
            OP_START: begin
              hvld_d = '0;
              ptr_d  = '0;
            end
            OP_RESIDUAL: begin
              mac_ctl.start = 1'b1;
              k_d     = '0;
              slot_d  = (ptr_q == '0) ? LAST : ptr_q - AW'(1);
              state_d = S_RUN;
            end
            default: begin
            end
          endcase
        end
      end
      S_RUN: begin
        // one tap and one history entry per cycle, newest output first
        rd_en  = 1'b1;
        tok_d  = 1'b1;
        hv_d   = hvld_q[slot_q];
        k_d    = k_q + AW'(1);
        slot_d = (slot_q == '0) ? LAST : slot_q - AW'(1);
        if (k_q == LAST) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!tok_q && !mac_busy) begin
          mac_ctl.finish = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_DONE: begin
        // write back and emit once the output register is free
        if (!out_valid_q || out_ready_i) begin
          hist_we        = 1'b1;
          hvld_d[ptr_q]  = 1'b1;
          ptr_d          = (ptr_q == LAST) ? '0 : ptr_q + AW'(1);
          out_valid_d    = 1'b1;
          out_d          = clamped;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign speech_sample_o = out_q;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for lpc_residual_synthesis_filter_top
// Loads every tap, walks a table of corner items, then runs random pitch
// segments (tap loads, start, residual bursts, dropped items). The input side
// sends in bursts with gaps and the output side stalls on its own pattern.
// Every sample is checked, against a typed corner value or an all-pole model.
// ----------------------------------------------------------------------------
module tb;
  import lrsf_pkg::*;

  localparam int NUM_TAPS     = FILTER_ORDER_DEF - 1;
  localparam int RAND_ITEMS   = 1000;
  localparam int DRAIN_CYCLES = FILTER_ORDER_DEF + 16;
  localparam int N_CORNER     = 25;
  localparam longint HIST_TOP    = 8388607;
  localparam longint HIST_BOTTOM = -8388608;
  localparam longint PCM_LIMIT   = 32766;

  // op code the block drops
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // one row of the corner table; pcm is typed in only where has_pcm is set
  typedef struct packed {
    logic [OP_W-1:0]              op;
    logic [TAP_IDX_W-1:0]         idx;
    logic signed [TAP_W-1:0]      val;
    logic [BYTE_W-1:0]            code;
    logic                         has_pcm;
    logic signed [SAMPLE_W-1:0]   pcm;
  } corner_row_t;

  localparam corner_row_t CORNER_ROWS [N_CORNER] = '{
    // taps all zero: output is the decoded excitation
    '{OP_RESIDUAL, 6'd0,  20'sd0,       8'h00, 1'b1, -16'sd32124},
    '{OP_RESIDUAL, 6'd63, -20'sd1,      8'h80, 1'b1, 16'sd32124},
    '{OP_RESIDUAL, 6'd0,  20'sd0,       8'hFF, 1'b1, 16'sd0},
    '{OP_RESIDUAL, 6'd0,  20'sd0,       8'h7F, 1'b1, 16'sd0},
    '{OP_RESIDUAL, 6'd0,  20'sd0,       8'h70, 1'b1, -16'sd120},
    '{OP_RESIDUAL, 6'd0,  20'sd0,       8'hF0, 1'b1, 16'sd120},
    // dropped items must leave the taps alone
    '{OP_UNUSED,   6'd63, -20'sd1,      8'hFF, 1'b0, 16'sd0},
    '{OP_LOAD,     6'd46, 20'sd524287,  8'h00, 1'b0, 16'sd0},
    '{OP_LOAD,     6'd63, -20'sd524288, 8'h00, 1'b0, 16'sd0},
    '{OP_RESIDUAL, 6'd0,  20'sd0,       8'h80, 1'b1, 16'sd32124},
    // extreme taps, positive runaway into the clamp
    '{OP_START,    6'd0,  20'sd0,       8'h00, 1'b0, 16'sd0},
    '{OP_LOAD,     6'd0,  20'sd524287,  8'h00, 1'b0, 16'sd0},
    '{OP_LOAD,     6'd45, -20'sd524288, 8'h00, 1'b0, 16'sd0},
    '{OP_RESIDUAL, 6'd0,  20'sd0,       8'h80, 1'b1, 16'sd32124},
    '{OP_RESIDUAL, 6'd0,  20'sd0,       8'h80, 1'b1, 16'sd32766},
    '{OP_RESIDUAL, 6'd0,  20'sd0,       8'h80, 1'b0, 16'sd0},
    // start clears history, negative runaway
    '{OP_START,    6'd0,  20'sd0,       8'h00, 1'b0, 16'sd0},
    '{OP_RESIDUAL, 6'd0,  20'sd0,       8'h00, 1'b1, -16'sd32124},
    '{OP_RESIDUAL, 6'd0,  20'sd0,       8'h00, 1'b1, -16'sd32766},
    '{OP_RESIDUAL, 6'd0,  20'sd0,       8'h00, 1'b0, 16'sd0},
    // unity feedback on the newest sample
    '{OP_LOAD,     6'd0,  20'sd65536,   8'h00, 1'b0, 16'sd0},
    '{OP_LOAD,     6'd45, 20'sd0,       8'h00, 1'b0, 16'sd0},
    '{OP_START,    6'd0,  20'sd0,       8'h00, 1'b0, 16'sd0},
    '{OP_RESIDUAL, 6'd0,  20'sd0,       8'h55, 1'b0, 16'sd0},
    '{OP_RESIDUAL, 6'd0,  20'sd0,       8'hAA, 1'b0, 16'sd0}
  };

  // DUT ports
  logic                        clk_i           = 1'b0;
  logic                        rst_ni          = 1'b0;
  logic                        in_valid_i      = 1'b0;
  logic                        in_ready_o;
  logic [OP_W-1:0]             op_i            = OP_LOAD;
  logic [TAP_IDX_W-1:0]        tap_index_i     = '0;
  logic signed [TAP_W-1:0]     tap_value_i     = '0;
  logic [BYTE_W-1:0]           residual_byte_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i     = 1'b0;
  logic signed [SAMPLE_W-1:0]  speech_sample_o;

  // filter model state
  logic signed [TAP_W-1:0]     tap_model  [NUM_TAPS];
  logic signed [HIST_W-1:0]    hist_model [NUM_TAPS];
  int                          hist_wr;
  logic signed [SAMPLE_W-1:0]  pcm_expected_q [$];

  // sender and receiver pacing
  int                          burst_left = 0;
  logic [15:0]                 rx_pattern = '1;
  int                          rx_pos     = 0;

  // run statistics
  int fails         = 0;
  int n_residual    = 0;
  int n_load        = 0;
  int n_start       = 0;
  int n_dropped     = 0;
  int n_checked     = 0;
  int n_clamped     = 0;

  lpc_residual_synthesis_filter_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .tap_index_i     (tap_index_i),
    .tap_value_i     (tap_value_i),
    .residual_byte_i (residual_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .speech_sample_o (speech_sample_o)
  );

  // 50 MHz clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // mu-law byte to excitation; segment base is 132 * (2^seg - 1)
  function automatic longint expand_mulaw(input logic [BYTE_W-1:0] code);
    logic [BYTE_W-1:0] inv;
    int                seg;
    longint            mag;
    inv = ~code;
    seg = inv[6:4];
    mag = longint'(132 * ((1 << seg) - 1)) + (longint'(inv[3:0]) << (seg + 3));
    return inv[7] ? -mag : mag;
  endfunction

  // one filter output: exact MAC, history saturation, output clamp
  function automatic logic signed [SAMPLE_W-1:0] synth_sample(input logic [BYTE_W-1:0] code);
    longint acc;
    longint y;
    int     slot;
    acc = expand_mulaw(code) * 65536;
    for (int k = 0; k < NUM_TAPS; k++) begin
      slot = (hist_wr + NUM_TAPS - 1 - k) % NUM_TAPS;
      acc += longint'(tap_model[k]) * longint'(hist_model[slot]);
    end
    y = acc / 65536;
    if (y > HIST_TOP) begin
      y = HIST_TOP;
    end else if (y < HIST_BOTTOM) begin
      y = HIST_BOTTOM;
    end
    hist_model[hist_wr] = HIST_W'(y);
    hist_wr = (hist_wr + 1) % NUM_TAPS;
    if (y > PCM_LIMIT) begin
      y = PCM_LIMIT;
    end else if (y < -PCM_LIMIT) begin
      y = -PCM_LIMIT;
    end
    return SAMPLE_W'(y);
  endfunction

  // drive one item, wait for it to be taken, then update the model
  task automatic send_item(input logic [OP_W-1:0] op, input logic [TAP_IDX_W-1:0] idx,
                           input logic signed [TAP_W-1:0] val,
                           input logic [BYTE_W-1:0] code, input logic has_pcm,
                           input logic signed [SAMPLE_W-1:0] typed_pcm);
    bit   taken;
    int   gap;
    logic signed [SAMPLE_W-1:0] pcm;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    op_i            <= op;
    tap_index_i     <= idx;
    tap_value_i     <= val;
    residual_byte_i <= code;
    // ready is sampled mid-cycle, the item is taken at the next rising edge
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);

    case (op)
      OP_LOAD: begin
        if (idx < NUM_TAPS) begin
          tap_model[idx] = val;
          n_load++;
        end else begin
          n_dropped++;
        end
      end
      OP_START: begin
        foreach (hist_model[i]) hist_model[i] = '0;
        hist_wr = 0;
        n_start++;
      end
      OP_RESIDUAL: begin
        pcm = synth_sample(code);
        pcm_expected_q.push_back(has_pcm ? typed_pcm : pcm);
        n_residual++;
      end
      default: begin
        n_dropped++;
      end
    endcase
  endtask

  // output stalls: a 16-bit ready pattern walked bit by bit, redrawn every fourth pass
  always @(posedge clk_i) begin
    if (rx_pos == 0) begin
      case ($urandom_range(0, 3))
        0:       rx_pattern = '1;
        1:       rx_pattern = 16'($urandom);
        2:       rx_pattern = 16'h0101;
        default: rx_pattern = 16'($urandom) | 16'($urandom);
      endcase
    end
    out_ready_i <= rx_pattern[rx_pos % 16];
    rx_pos = (rx_pos + 1) % 64;
  end

  // sample check; handshake signals are stable mid-cycle
  always @(negedge clk_i) begin : sample_check
    logic signed [SAMPLE_W-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pcm_expected_q.size() == 0) begin
        $error("speech_sample: no sample expected, got %0d", speech_sample_o);
        fails++;
      end else begin
        want = pcm_expected_q.pop_front();
        if (want !== speech_sample_o) begin
          $error("speech_sample: expected %0d, actual %0d", want, speech_sample_o);
          fails++;
        end
        n_checked++;
        if (speech_sample_o == 16'sd32766 || speech_sample_o == -16'sd32766) begin
          n_clamped++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int                       rand_items;
    int                       shift;
    int                       n_taps;
    int                       n_res;
    logic [TAP_IDX_W-1:0]     idx;
    logic signed [TAP_W-1:0]  val;
    rand_items = 0;
    foreach (tap_model[i]) tap_model[i] = '0;
    foreach (hist_model[i]) hist_model[i] = '0;
    hist_wr = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every tap is written before the first residual item
    for (int k = 0; k < NUM_TAPS; k++) begin
      send_item(OP_LOAD, TAP_IDX_W'(k), '0, '0, 1'b0, '0);
    end

    // corner table
    for (int i = 0; i < N_CORNER; i++) begin
      send_item(CORNER_ROWS[i].op, CORNER_ROWS[i].idx, CORNER_ROWS[i].val,
                CORNER_ROWS[i].code, CORNER_ROWS[i].has_pcm, CORNER_ROWS[i].pcm);
    end

    // random pitch segments: tap updates, mostly a start, then residuals
    while (rand_items < RAND_ITEMS) begin
      shift  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : $urandom_range(8, 15);
      n_taps = ($urandom_range(0, 9) == 0) ? NUM_TAPS : $urandom_range(0, 6);
      for (int j = 0; j < n_taps; j++) begin
        idx = (n_taps == NUM_TAPS) ? TAP_IDX_W'(j) : TAP_IDX_W'($urandom_range(0, NUM_TAPS - 1));
        val = $signed(TAP_W'($urandom)) >>> shift;
        send_item(OP_LOAD, idx, val, BYTE_W'($urandom), 1'b0, '0);
        rand_items++;
      end
      if ($urandom_range(0, 4) != 0) begin
        send_item(OP_START, TAP_IDX_W'($urandom), TAP_W'($urandom), BYTE_W'($urandom),
                  1'b0, '0);
        rand_items++;
      end
      n_res = $urandom_range(1, 40);
      for (int j = 0; j < n_res; j++) begin
        // occasional dropped item between residuals
        if ($urandom_range(0, 19) == 0) begin
          if ($urandom_range(0, 1) == 0) begin
            send_item(OP_UNUSED, TAP_IDX_W'($urandom), TAP_W'($urandom),
                      BYTE_W'($urandom), 1'b0, '0);
          end else begin
            send_item(OP_LOAD, TAP_IDX_W'($urandom_range(NUM_TAPS, 63)), TAP_W'($urandom),
                      BYTE_W'($urandom), 1'b0, '0);
          end
        end
        send_item(OP_RESIDUAL, TAP_IDX_W'($urandom), TAP_W'($urandom), BYTE_W'($urandom),
                  1'b0, '0);
        rand_items++;
      end
    end
    in_valid_i <= 1'b0;

    // wait for the last samples, then watch for strays
    while (pcm_expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d residual, %0d tap load, %0d start and %0d dropped items",
             n_residual, n_load, n_start, n_dropped);
    $display("%0d samples checked, %0d of them at the output clamp", n_checked, n_clamped);
    if (fails == 0) begin
      $display("** lpc_residual_synthesis_filter_top: PASSED **");
    end else begin
      $display("** lpc_residual_synthesis_filter_top: FAILED **");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #10_000_000;
    $display("** lpc_residual_synthesis_filter_top: FAILED **");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/lrsf_pkg.sv
sv/lrsf_ram.sv
sv/lrsf_mac.sv
sv/lpc_residual_synthesis_filter_top.sv
sim/tb.sv
